// File: hw/rtl/bafe_pkg.sv
// ----------------------------------------------------------------------------
// bafe_pkg
// shared types, constants and byte-wide helper functions of the advertising
// frame encoder
// ----------------------------------------------------------------------------
`default_nettype none

package bafe_pkg;

    // frame layout
    localparam logic [4:0] FRAME_LAST = 5'd30;
    localparam logic [4:0] ENC_START  = 5'd7;   // first whitened byte
    localparam logic [4:0] MAP_START  = 5'd15;  // first data map byte
    localparam logic [4:0] ICRC_HI    = 5'd27;
    localparam logic [4:0] ICRC_LO    = 5'd28;
    localparam logic [4:0] OCRC_HI    = 5'd29;

    // crc pass: 12 map bytes, then the two inner crc bytes into the outer crc
    localparam logic [3:0] MAP_CRC_BYTES = 4'd12;
    localparam logic [3:0] CRC_INNER_HI  = 4'd12;
    localparam logic [3:0] CRC_PASS_DONE = 4'd14;

    localparam logic [15:0] SEED_MASK   = 16'hFFF5;
    localparam logic [7:0]  ID_MID_MASK = 8'hF0;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [6:0]  LFSR_INIT   = 7'h6F;
    localparam logic [7:0]  LFSR_TAPS   = 8'h11;

    localparam logic [7:0] HDR_BYTES [0:6] = '{
        8'h02, 8'h01, 8'h01, 8'h1B, 8'h03, 8'h77, 8'hF8
    };

    localparam logic [7:0] PREFIX_BYTES [0:7] = '{
        8'hAA, 8'h98, 8'h43, 8'hAF, 8'h0B, 8'h46, 8'h46, 8'h46
    };

    typedef struct packed {
        logic init;
        logic en;
    } crc_ctl_t;

    typedef struct packed {
        logic [7:0] mask;
        logic [6:0] lfsr;
    } wh_step_t;

    // crc16 ccitt, msb first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (crc[15])
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            else
                crc = {crc[14:0], 1'b0};
        end
        return crc;
    endfunction

    // outer crc start value: prefix bytes one through five from all ones
    function automatic logic [15:0] prefix_crc();
        logic [15:0] crc;
        crc = 16'hFFFF;
        for (int i = 1; i < 6; i++) begin
            crc = crc16_byte(crc, PREFIX_BYTES[i]);
        end
        return crc;
    endfunction

    localparam logic [15:0] OUTER_SEED = prefix_crc();

    function automatic logic [7:0] bit_rev8(input logic [7:0] x);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = x[7-i];
        end
        return r;
    endfunction

    // eight lfsr shifts, mask collected lsb first
    function automatic wh_step_t whiten_step(input logic [6:0] lfsr_in);
        wh_step_t   res;
        logic [7:0] r;
        logic [6:0] s;
        s = lfsr_in;
        res.mask = 8'h00;
        for (int j = 0; j < 8; j++) begin
            r = {s, 1'b0};
            if (r[7]) begin
                r = r ^ LFSR_TAPS;
                res.mask[j] = 1'b1;
            end
            s = r[6:0];
        end
        res.lfsr = s;
        return res;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bafe_crc16.sv
// ----------------------------------------------------------------------------
// bafe_crc16
// byte-serial crc16 register: loads a seed, then while enabled folds in one byte per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module bafe_crc16
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bafe_pkg::crc_ctl_t ctl,
    input  wire logic [15:0]        seed,
    input  wire logic [7:0]         data,
    output logic [15:0]             crc
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    always_comb
    begin
        crc_next = crc_reg;
        if (ctl.init)
            crc_next = seed;
        else if (ctl.en)
            crc_next = bafe_pkg::crc16_byte(crc_reg, data);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= 16'h0000;
        else
            crc_reg <= crc_next;
    end

    assign crc = crc_reg;

endmodule

`default_nettype wire

// File: hw/rtl/bafe_whitener.sv
// ----------------------------------------------------------------------------
// bafe_whitener
// bit reversal and 7-bit lfsr whitening, one byte per advance
// ----------------------------------------------------------------------------
`default_nettype none

module bafe_whitener
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       restart,
    input  wire logic       advance,
    input  wire logic [7:0] raw_byte,
    output logic [7:0]      coded_byte
);

    logic [6:0]         lfsr_reg;
    logic [6:0]         lfsr_next;
    bafe_pkg::wh_step_t step;

    assign step       = bafe_pkg::whiten_step(lfsr_reg);
    assign coded_byte = bafe_pkg::bit_rev8(raw_byte) ^ step.mask;

    always_comb
    begin
        lfsr_next = lfsr_reg;
        if (restart)
            lfsr_next = bafe_pkg::LFSR_INIT;
        else if (advance)
            lfsr_next = step.lfsr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lfsr_reg <= bafe_pkg::LFSR_INIT;
        else
            lfsr_reg <= lfsr_next;
    end

endmodule

`default_nettype wire

// File: hw/rtl/ble_adv_frame_encoder.sv
// ----------------------------------------------------------------------------
// ble_adv_frame_encoder
// turns one lamp command into the 31-byte advertising payload, one byte per
// output transaction, with inner/outer crc16 and lfsr whitening
// ----------------------------------------------------------------------------
//
//  channel   dir  width  transaction
//  s_axis    in   80     one lamp command
//  m_axis    out  16     one payload byte, tlast on byte 30
//
//  when the output never stalls, a command is accepted and then one byte per
//  cycle goes through the output register; the output byte stream is what
//  sets the pace
//  the crc pass (one byte per cycle) runs under the header and prefix
//  bytes; a map byte is only released once that pass is done
//  output stalls hold the byte in the output register and freeze the stream
//  the next command is taken as soon as byte 30 sits in the output register
//  reset: idle, output register empty, lfsr at 0x6F
//
`default_nettype none

module ble_adv_frame_encoder
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] opcode, [15:8] arg_zero, [23:16] arg_one, [31:24] arg_two,
    // [55:32] remote_id, [63:56] tx_counter, [79:64] random_word
    input  wire logic [79:0] s_axis_tdata,
    // payload byte out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] frame_byte, [12:8] byte_index, [15:13] zero
    output logic [15:0]      m_axis_tdata,
    output logic             m_axis_tlast   // last_byte
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_BUSY = 2'b10
    } state_t;

    state_t      state_reg;
    state_t      state_next;

    // command fields
    logic [7:0]  opcode;
    logic [7:0]  arg_zero;
    logic [7:0]  arg_one;
    logic [7:0]  arg_two;
    logic [23:0] remote_id;
    logic [7:0]  tx_counter;
    logic [15:0] random_word;
    logic [15:0] seed;

    assign opcode        = s_axis_tdata[7:0];
    assign arg_zero      = s_axis_tdata[15:8];
    assign arg_one       = s_axis_tdata[23:16];
    assign arg_two       = s_axis_tdata[31:24];
    assign remote_id     = s_axis_tdata[55:32];
    assign tx_counter    = s_axis_tdata[63:56];
    assign random_word   = s_axis_tdata[79:64];
    assign seed          = random_word & bafe_pkg::SEED_MASK;

    // data map bytes 0..11, rotated one byte per cycle when rotate is set, byte 0 is the tap
    logic [7:0]  map_reg  [12];
    logic [7:0]  map_next [12];

    logic [3:0]  crc_cnt_reg;    // crc pass progress
    logic [3:0]  crc_cnt_next;
    logic [4:0]  idx_reg;        // index of the next byte to load
    logic [4:0]  idx_next;

    // output register
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic [7:0]  out_byte_next;
    logic [4:0]  out_idx_reg;
    logic [4:0]  out_idx_next;
    logic        out_last_reg;
    logic        out_last_next;

    logic        accept;
    logic        busy;
    logic        crc_map_phase;
    logic        crc_done;
    logic        out_free;
    logic        src_ok;
    logic        load;
    logic        rotate;
    logic        is_hdr;

    bafe_pkg::crc_ctl_t inner_ctl;
    bafe_pkg::crc_ctl_t outer_ctl;
    logic [15:0] inner_crc;
    logic [15:0] outer_crc;
    logic [7:0]  outer_data;
    logic [7:0]  raw_byte;
    logic [7:0]  coded_byte;
    logic [2:0]  prefix_sel;

    assign busy          = (state_reg == S_BUSY);
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign crc_map_phase = busy && (crc_cnt_reg < bafe_pkg::MAP_CRC_BYTES);
    assign crc_done      = (crc_cnt_reg == bafe_pkg::CRC_PASS_DONE);

    // header and prefix bytes are constants, everything later waits on the crcs
    assign out_free = !out_valid_reg || m_axis_tready;
    assign src_ok   = (idx_reg < bafe_pkg::MAP_START) || crc_done;
    assign load     = busy && out_free && src_ok;
    assign is_hdr   = (idx_reg < bafe_pkg::ENC_START);

    // the map register turns during the crc pass and again while map bytes go out
    assign rotate = crc_map_phase ||
                    (load && (idx_reg >= bafe_pkg::MAP_START) &&
                     (idx_reg < bafe_pkg::ICRC_HI));

    // crc units
    assign inner_ctl.init = accept;
    assign inner_ctl.en   = crc_map_phase;
    assign outer_ctl.init = accept;
    assign outer_ctl.en   = busy && !crc_done;

    always_comb
    begin
        if (crc_cnt_reg < bafe_pkg::MAP_CRC_BYTES)
            outer_data = map_reg[0];
        else if (crc_cnt_reg == bafe_pkg::CRC_INNER_HI)
            outer_data = inner_crc[15:8];
        else
            outer_data = inner_crc[7:0];
    end

    bafe_crc16 u_inner_crc
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (inner_ctl),
        .seed  (~seed),
        .data  (map_reg[0]),
        .crc   (inner_crc)
    );

    bafe_crc16 u_outer_crc
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (outer_ctl),
        .seed  (bafe_pkg::OUTER_SEED),
        .data  (outer_data),
        .crc   (outer_crc)
    );

    // byte source for the whitened part of the frame
    assign prefix_sel = 3'(idx_reg - bafe_pkg::ENC_START);

    always_comb
    begin
        if (idx_reg < bafe_pkg::MAP_START)
            raw_byte = bafe_pkg::PREFIX_BYTES[prefix_sel];
        else if (idx_reg < bafe_pkg::ICRC_HI)
            raw_byte = map_reg[0];
        else if (idx_reg == bafe_pkg::ICRC_HI)
            raw_byte = inner_crc[15:8];
        else if (idx_reg == bafe_pkg::ICRC_LO)
            raw_byte = inner_crc[7:0];
        else if (idx_reg == bafe_pkg::OCRC_HI)
            raw_byte = outer_crc[15:8];
        else
            raw_byte = outer_crc[7:0];
    end

    bafe_whitener u_whitener
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (accept),
        .advance    (load && !is_hdr),
        .raw_byte   (raw_byte),
        .coded_byte (coded_byte)
    );

    // map register
    always_comb
    begin
        for (int i = 0; i < 12; i++) begin
            map_next[i] = map_reg[i];
        end
        if (accept) begin
            map_next[0]  = opcode;
            map_next[1]  = remote_id[7:0];
            map_next[2]  = remote_id[15:8] & bafe_pkg::ID_MID_MASK;
            map_next[3]  = arg_zero;
            map_next[4]  = arg_one;
            map_next[5]  = arg_two;
            map_next[6]  = tx_counter;
            map_next[7]  = 8'h00;
            map_next[8]  = seed[7:0] ^ remote_id[23:16];
            map_next[9]  = seed[7:0];
            map_next[10] = seed[15:8];
            map_next[11] = seed[7:0];
        end
        else if (rotate) begin
            for (int i = 0; i < 11; i++) begin
                map_next[i] = map_reg[i+1];
            end
            map_next[11] = map_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 12; i++) begin
            map_reg[i] <= map_next[i];
        end
    end

    // control and output register
    always_comb
    begin
        state_next     = state_reg;
        crc_cnt_next   = crc_cnt_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        if (busy && !crc_done)
            crc_cnt_next = crc_cnt_reg + 4'd1;

        if (load) begin
            out_valid_next = 1'b1;
            out_byte_next  = is_hdr ? bafe_pkg::HDR_BYTES[idx_reg[2:0]] : coded_byte;
            out_idx_next   = idx_reg;
            out_last_next  = (idx_reg == bafe_pkg::FRAME_LAST);
            idx_next       = idx_reg + 5'd1;
            if (idx_reg == bafe_pkg::FRAME_LAST)
                state_next = S_IDLE;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept) begin
                    state_next   = S_BUSY;
                    crc_cnt_next = 4'd0;
                    idx_next     = 5'd0;
                end
            end
            S_BUSY:
            begin
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            crc_cnt_reg   <= bafe_pkg::CRC_PASS_DONE;
            idx_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            crc_cnt_reg   <= crc_cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_idx_reg, out_byte_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

// File: hw/rtl/bafe_checker.sv
// ----------------------------------------------------------------------------
// bafe_checker
// port-level checks on the advertising frame encoder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module bafe_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [15:0] m_axis_tdata,
    input  wire logic        m_axis_tlast
);

    // tlast marks exactly byte 30
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[12:8] == 5'd30)))
        else $error("tlast does not match byte index");

    // first header byte is fixed
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[12:8] == 5'd0)) |-> (m_axis_tdata[7:0] == 8'h02))
        else $error("header byte 0 wrong");

    // a command in flight blocks the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("command accepted while busy");

    // frame not finished while bytes before 29 are being taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && (m_axis_tdata[12:8] < 5'd29)) |=> !s_axis_tready)
        else $error("input opened before frame end");

    // stalled output transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output changed");

endmodule

bind ble_adv_frame_encoder bafe_checker u_bafe_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
